// ===== rtl/core/abba_pkg.sv =====
// Shared types and constants for the aligned bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package abba_pkg;
    // Blocks per occupancy map; the 10-bit block index fields are sized for it.
    localparam int MAP_BLOCKS = 1024;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_INVAL  = 2'd1;
    localparam logic [1:0] ST_UNSUP  = 2'd2;
    localparam logic [1:0] ST_NOMEM  = 2'd3;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [1:0] RG_STEER   = 2'd0;
    localparam logic [1:0] RG_HDR     = 2'd1;
    localparam logic [1:0] RG_PATTERN = 2'd2;
    localparam logic [1:0] RG_INVALID = 2'd3;

    localparam logic [2:0] REG_LOG_BLOCK  = 3'd0;
    localparam logic [2:0] REG_STEER_BASE = 3'd1;
    localparam logic [2:0] REG_STEER_LOG  = 3'd2;
    localparam logic [2:0] REG_HDR_BASE   = 3'd3;
    localparam logic [2:0] REG_HDR_LOG    = 3'd4;
    localparam logic [2:0] REG_PAT_BASE   = 3'd5;
    localparam logic [2:0] REG_PAT_LOG    = 3'd6;
    localparam logic [2:0] REG_PAT_EN     = 3'd7;

    // Controller commands to the datapath.
    typedef struct packed {
        logic clear_step;  // advance clear sweep by one address
        logic load;        // capture request and run the checks
        logic cand_start;  // start checking run at current candidate
        logic scan_step;   // test one block, advance run counter
        logic next_cand;   // advance candidate by alignment step
        logic mark_start;  // restart counter for marking the run
        logic mark_step;   // write one block of the run
        logic set_nomem;   // override result with no memory
    } abba_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic clear_done;
        logic early;       // request finished at the checks
        logic is_release;
        logic cand_ok;     // candidate run fits in the region
        logic rd_valid;    // read data for the block under test is ready
        logic blk_busy;    // block under test is used
        logic run_last;    // current block is the run's last
    } abba_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/aligned_bitmap_block_allocator.sv =====
// Top level of the aligned bitmap block allocator.
//
// Usage: requests enter on the s_axis channel; one result per request leaves
// on the m_axis channel. Write configuration through cfg_we/cfg_index/cfg_wdata
// only while no request is in work.
// Reset: the block clears its bitmap memory of 3*MAP_BLOCKS entries, one entry
// a cycle, with s_axis_tready low; configuration writes are taken throughout.
// Path from the request transfer to m_axis_tvalid: a check state, then
//  - rejected request: nothing more;
//  - release: a marking state that clears the run block by block;
//  - allocation: candidates step by the alignment; each is checked to fit,
//    then its blocks are tested through a registered memory read; the run
//    is then marked block by block; a no-memory result ends at a failed fit check.
// Throughput: one request in work at a time; s_axis_tready rises the cycle
// after the result transfer. While m_axis_tready is low, hold the result unchanged.
`timescale 1ns / 1ps
`default_nettype none
module aligned_bitmap_block_allocator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[0], region_type[2:1], length_bytes[43:3], log_align[49:44],
    // release_index[59:50], zero pad [63:60]
    input  wire  [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[1:0], address[65:2], block_index[75:66], log_size[81:76], pad
    output logic [87:0] m_axis_tdata
);
    abba_pkg::abba_cmd_t cmd;
    abba_pkg::abba_sts_t sts;
    logic [1:0]  r_status;
    logic [63:0] r_address;
    logic [9:0]  r_block;
    logic [5:0]  r_lsz;

    abba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .sts       (sts),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    abba_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_operation     (s_axis_tdata[0]),
        .in_region_type   (s_axis_tdata[2:1]),
        .in_length_bytes  (s_axis_tdata[43:3]),
        .in_log_align     (s_axis_tdata[49:44]),
        .in_release_index (s_axis_tdata[59:50]),
        .cmd              (cmd),
        .sts              (sts),
        .res_status       (r_status),
        .res_address      (r_address),
        .res_block_index  (r_block),
        .res_log_size     (r_lsz)
    );

    assign m_axis_tdata = {6'd0, r_lsz, r_block, r_address, r_status};
endmodule
`default_nettype wire

// ===== rtl/core/abba_ctrl.sv =====
// Controller state machine for the aligned bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
module abba_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_fire,
    input  wire                 out_fire,
    input  abba_pkg::abba_sts_t sts,
    output logic                in_ready,
    output logic                out_valid,
    output abba_pkg::abba_cmd_t cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_CAND  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_MARK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.clear_step = 1'b1;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.early) begin
                    state_next = S_OUT;
                end else if (sts.is_release) begin
                    cmd.mark_start = 1'b1;
                    state_next     = S_MARK;
                end else begin
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                if (sts.cand_ok) begin
                    cmd.cand_start = 1'b1;
                    state_next     = S_SCAN;
                end else begin
                    cmd.set_nomem = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_SCAN: begin
                // Wait for the registered read, then act on the tested block.
                if (sts.rd_valid) begin
                    if (sts.blk_busy) begin
                        cmd.next_cand = 1'b1;
                        state_next    = S_CAND;
                    end else if (sts.run_last) begin
                        cmd.mark_start = 1'b1;
                        state_next     = S_MARK;
                    end else begin
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            S_MARK: begin
                cmd.mark_step = 1'b1;
                if (sts.run_last) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/abba_datapath.sv =====
// Datapath: request checks, bitmap storage, run counters and result assembly.
`timescale 1ns / 1ps
`default_nettype none
module abba_datapath (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_index,
    input  wire  [63:0]         cfg_wdata,
    input  wire                 in_operation,
    input  wire  [1:0]          in_region_type,
    input  wire  [40:0]         in_length_bytes,
    input  wire  [5:0]          in_log_align,
    input  wire  [9:0]          in_release_index,
    input  abba_pkg::abba_cmd_t cmd,
    output abba_pkg::abba_sts_t sts,
    output logic [1:0]          res_status,
    output logic [63:0]         res_address,
    output logic [9:0]          res_block_index,
    output logic [5:0]          res_log_size
);
    localparam int AW = $clog2(abba_pkg::MAP_BLOCKS);
    localparam int CW = AW + 1;        // holds MAP_BLOCKS itself

    // Configuration registers.
    logic [5:0]  log_blk_reg;
    logic [63:0] steer_base_reg, hdr_base_reg, pat_base_reg;
    logic [5:0]  steer_log_reg, hdr_log_reg, pat_log_reg;
    logic        pat_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_blk_reg    <= '0;
            steer_base_reg <= '0;
            steer_log_reg  <= '0;
            hdr_base_reg   <= '0;
            hdr_log_reg    <= '0;
            pat_base_reg   <= '0;
            pat_log_reg    <= '0;
            pat_en_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                abba_pkg::REG_LOG_BLOCK:  log_blk_reg    <= cfg_wdata[5:0];
                abba_pkg::REG_STEER_BASE: steer_base_reg <= cfg_wdata;
                abba_pkg::REG_STEER_LOG:  steer_log_reg  <= cfg_wdata[5:0];
                abba_pkg::REG_HDR_BASE:   hdr_base_reg   <= cfg_wdata;
                abba_pkg::REG_HDR_LOG:    hdr_log_reg    <= cfg_wdata[5:0];
                abba_pkg::REG_PAT_BASE:   pat_base_reg   <= cfg_wdata;
                abba_pkg::REG_PAT_LOG:    pat_log_reg    <= cfg_wdata[5:0];
                abba_pkg::REG_PAT_EN:     pat_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Request checks, evaluated on the input transfer.
    logic [40:0] blk_mask;
    logic        len_bad;
    logic [63:0] sel_base;
    logic [5:0]  sel_log;
    logic        sel_present;
    logic [5:0]  lsz;
    logic [5:0]  diff;
    logic [CW-1:0] nblk;
    logic [41:0] need_w;
    logic [5:0]  la_eff, shift;

    always_comb begin
        blk_mask = (log_blk_reg >= 6'd41) ? '1 : ((41'd1 << log_blk_reg) - 41'd1);
        len_bad  = (in_length_bytes == '0)
                || ((in_length_bytes & (in_length_bytes - 41'd1)) != '0)
                || ((in_length_bytes & blk_mask) != '0);
        sel_base = steer_base_reg;
        sel_log  = steer_log_reg;
        sel_present = 1'b0;
        case (in_region_type)
            abba_pkg::RG_STEER: begin
                sel_present = steer_base_reg != '0;
            end
            abba_pkg::RG_HDR: begin
                sel_base = hdr_base_reg; sel_log = hdr_log_reg;
                sel_present = hdr_base_reg != '0;
            end
            abba_pkg::RG_PATTERN: begin
                sel_base = pat_base_reg; sel_log = pat_log_reg;
                sel_present = (pat_base_reg != '0) && pat_en_reg;
            end
            default: sel_present = 1'b0;
        endcase
        // Encode the single set bit of a valid length.
        lsz = '0;
        for (int b = 0; b < 41; b++) begin
            if (in_length_bytes[b]) lsz = 6'(b);
        end
        diff = sel_log - log_blk_reg;
        if (sel_log < log_blk_reg) begin
            nblk = '0;
        end else if (diff >= 6'(AW)) begin
            nblk = CW'(abba_pkg::MAP_BLOCKS);
        end else begin
            nblk = CW'(1) << diff;
            if (nblk > CW'(abba_pkg::MAP_BLOCKS)) nblk = CW'(abba_pkg::MAP_BLOCKS);
        end
        need_w = {1'b0, in_length_bytes} >> log_blk_reg;
        la_eff = (in_log_align < log_blk_reg) ? log_blk_reg : in_log_align;
        shift  = la_eff - log_blk_reg;
    end

    // Captured request.
    logic [1:0]    status_reg;
    logic          early_reg, rel_reg;
    logic [63:0]   base_reg;
    logic [5:0]    lsz_reg;
    logic [CW-1:0] nblk_reg;
    logic [CW-1:0] need_reg;
    logic [CW-1:0] step_reg;
    logic          bigstep_reg;
    logic [1:0]    rgn_reg;
    logic [CW-1:0] cand_reg;
    logic          cand_wrap_reg;
    logic [CW-1:0] off_reg;

    logic need_big;
    assign need_big = (need_w > 42'(abba_pkg::MAP_BLOCKS));

    logic [1:0] chk_status;
    logic       chk_early;

    always_comb begin
        chk_early = 1'b1;
        if (len_bad || in_region_type == abba_pkg::RG_INVALID) begin
            chk_status = abba_pkg::ST_INVAL;
        end else if (!sel_present) begin
            chk_status = abba_pkg::ST_UNSUP;
        end else if (in_operation == abba_pkg::OP_RELEASE &&
                     (need_big || need_w[CW-1:0] > nblk ||
                      {1'b0, CW'(in_release_index)} >
                      {1'b0, nblk} - {1'b0, need_w[CW-1:0]})) begin
            chk_status = abba_pkg::ST_INVAL;
        end else begin
            chk_status = abba_pkg::ST_OK;
            chk_early  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rgn_reg  <= in_region_type;
            base_reg <= sel_base;
            lsz_reg  <= lsz;
            nblk_reg <= nblk;
            // An oversized run saturates just past the map so it never fits.
            need_reg <= need_big ? CW'(abba_pkg::MAP_BLOCKS + 1) : need_w[CW-1:0];
            rel_reg  <= (in_operation == abba_pkg::OP_RELEASE);
            bigstep_reg <= (shift >= 6'(AW));
            step_reg <= (shift >= 6'(AW)) ? CW'(0) : (CW'(1) << shift);
            cand_reg <= (in_operation == abba_pkg::OP_RELEASE)
                        ? CW'(in_release_index) : '0;
            cand_wrap_reg <= 1'b0;
            early_reg  <= chk_early;
            status_reg <= chk_status;
        end else begin
            if (cmd.next_cand) begin
                if (bigstep_reg || ({1'b0, cand_reg} + {1'b0, step_reg} > {1'b0, nblk_reg})) begin
                    cand_wrap_reg <= 1'b1;
                end else begin
                    cand_reg <= cand_reg + step_reg;
                end
            end
            if (cmd.set_nomem) status_reg <= abba_pkg::ST_NOMEM;
        end
        if (cmd.cand_start || cmd.mark_start) begin
            off_reg <= '0;
        end else if (cmd.scan_step || cmd.mark_step) begin
            off_reg <= off_reg + CW'(1);
        end
    end

    // Candidate fits when it exists and cand + need <= nblk.
    logic [CW:0] cand_end;
    assign cand_end = {1'b0, cand_reg} + {1'b0, need_reg};
    assign sts.cand_ok = !cand_wrap_reg && (need_reg != '0)
                         && (cand_end <= {1'b0, nblk_reg});

    // Bitmap memory: three regions share one array, region selects the row.
    logic          map_mem [3*abba_pkg::MAP_BLOCKS];
    logic [AW+1:0] clr_addr_reg;
    logic          rd_bit;
    logic [AW+1:0] blk_addr;
    logic [CW-1:0] blk_pos;
    logic          clear_done_reg;

    assign blk_pos  = cand_reg + off_reg;
    assign blk_addr = (AW+2)'(rgn_reg) * (AW+2)'(abba_pkg::MAP_BLOCKS)
                    + (AW+2)'(blk_pos[AW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            clear_done_reg <= 1'b0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + (AW+2)'(1);
            if (clr_addr_reg == (AW+2)'(3*abba_pkg::MAP_BLOCKS - 1)) clear_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            map_mem[clr_addr_reg] <= 1'b0;
        end else if (cmd.mark_step) begin
            map_mem[blk_addr] <= !rel_reg;
        end
        rd_bit <= map_mem[blk_addr];
    end

    // Scan reads are registered: a test cycle alternates address and data.
    logic scan_ph_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) scan_ph_reg <= 1'b0;
        else if (cmd.cand_start || cmd.scan_step || cmd.next_cand) scan_ph_reg <= 1'b0;
        else scan_ph_reg <= 1'b1;
    end

    logic last_blk;
    assign last_blk = (off_reg + CW'(1) == need_reg);

    assign sts.clear_done = clear_done_reg;
    assign sts.early      = early_reg;
    assign sts.is_release = rel_reg;
    assign sts.rd_valid   = scan_ph_reg;
    assign sts.blk_busy   = rd_bit;
    assign sts.run_last   = last_blk;

    logic ok;
    assign ok = (status_reg == abba_pkg::ST_OK);
    assign res_status      = status_reg;
    assign res_address     = ok ? base_reg + ({{(64-CW){1'b0}}, cand_reg} << log_blk_reg) : '0;
    assign res_block_index = ok ? 10'(cand_reg) : '0;
    assign res_log_size    = ok ? lsz_reg : '0;
endmodule
`default_nettype wire

// ===== rtl/core/abba_checker.sv =====
// Port-level checker for the aligned bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
module abba_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [87:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[81:2] == '0)
        else $error("error result carries data");
    a_no_ready_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken early");
endmodule

bind aligned_bitmap_block_allocator abba_checker u_abba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
